@@ design/assert_macros.svh @@
// assertion macros for the rtl of the three-axis conditioner
// depends on nothing; files take it by include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, silent while reset is held
`define ASSERT_CLKD(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/mte3_pkg.sv @@
// package for the three-axis median and smoothing conditioner
// constants, request codes and default parameter values; depends on nothing
package mte3_pkg;

    localparam int AXES                = 3;
    localparam int AXIS_BITS           = 2;
    localparam int DEFAULT_WINDOW_LEN  = 5;
    localparam int DEFAULT_SAMPLE_BITS = 10;

    // request codes
    localparam logic REQ_SEED   = 1'b0;
    localparam logic REQ_FILTER = 1'b1;

    // axis code with no axis behind it
    localparam logic [AXIS_BITS-1:0] AXIS_UNUSED = 2'd3;

endpackage

@@ design/median_then_ema_three_axis_core.sv @@
// Three-axis sample conditioner: a per-axis median filter followed by a shift-add smoother.
// A user sees one result transaction for every input transaction on axis x, y or z,
// in order; axis code 3 is taken and dropped. Rate is one transaction per clock while
// m_ready does not stall the result channel. The path is the input register, then a
// single pass of logic that picks the median by ranking every window entry against
// every other with parallel comparators, does the shift-add and writes both the axis
// state and the result register. Since the axis state is written with the result, the next
// transaction, for any axis, sees it at once. A seed (req_type 0) fills the axis
// window with the sample, clears its write slot, loads the previous output and
// returns the sample; a filter request (req_type 1) replaces the oldest window entry,
// takes the median M and returns (prev >> 2) + 3 * (M >> 2). All windows read as
// zero after reset. Depends on mte3_pkg and assert_macros.svh.
`include "assert_macros.svh"

module median_then_ema_three_axis_core #(
    parameter int WINDOW_LEN  = mte3_pkg::DEFAULT_WINDOW_LEN,
    parameter int SAMPLE_BITS = mte3_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [mte3_pkg::AXIS_BITS-1:0] s_axis,
    input  logic [SAMPLE_BITS-1:0]         s_sample,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [mte3_pkg::AXIS_BITS-1:0] m_axis_out,
    output logic [SAMPLE_BITS-1:0]         m_filtered
);

    localparam int SLOT_BITS = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int MED_IDX   = (WINDOW_LEN - 1) / 2;
    localparam int AXES      = mte3_pkg::AXES;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [SLOT_BITS-1:0]   slot_t;

    // input register stage
    logic                           in_valid_reg;
    logic                           in_req_reg;
    logic [mte3_pkg::AXIS_BITS-1:0] in_axis_reg;
    sample_t                        in_sample_reg;

    // result register stage
    logic                           m_valid_reg;
    logic [mte3_pkg::AXIS_BITS-1:0] m_axis_reg;
    sample_t                        m_filtered_reg;

    // per-axis state
    sample_t win_reg  [AXES][WINDOW_LEN];
    slot_t   slot_reg [AXES];
    sample_t prev_reg [AXES];

    // working values for the transaction in the input register
    sample_t new_win   [WINDOW_LEN];
    slot_t   slot_next;
    sample_t median;
    sample_t result_next;

    logic out_ready;
    logic fire;

    // result register frees up when empty or being taken
    assign out_ready = !m_valid_reg || m_ready;
    assign fire      = in_valid_reg && out_ready;
    assign s_ready   = !in_valid_reg || out_ready;

    assign m_valid    = m_valid_reg;
    assign m_axis_out = m_axis_reg;
    assign m_filtered = m_filtered_reg;

    // window after writing the new sample, plus the next write slot
    always_comb begin
        slot_t cur_slot;
        cur_slot = slot_reg[in_axis_reg];
        for (int k = 0; k < WINDOW_LEN; k++) begin
            if (in_req_reg == mte3_pkg::REQ_SEED || cur_slot == slot_t'(k)) begin
                new_win[k] = in_sample_reg;
            end else begin
                new_win[k] = win_reg[in_axis_reg][k];
            end
        end
        if (in_req_reg == mte3_pkg::REQ_SEED || cur_slot >= slot_t'(WINDOW_LEN - 1)) begin
            slot_next = '0;
        end else begin
            slot_next = cur_slot + slot_t'(1);
        end
    end

    // median by rank: ties broken by position so exactly one entry holds each rank
    always_comb begin
        logic [WINDOW_LEN-1:0] below [WINDOW_LEN];
        logic [WINDOW_LEN-1:0] hit;
        median = '0;
        for (int i = 0; i < WINDOW_LEN; i++) begin
            for (int j = 0; j < WINDOW_LEN; j++) begin
                below[i][j] = (new_win[j] < new_win[i]) ||
                              ((new_win[j] == new_win[i]) && (j < i));
            end
            hit[i] = (slot_t'($countones(below[i])) == slot_t'(MED_IDX));
        end
        for (int i = 0; i < WINDOW_LEN; i++) begin
            median = median | (new_win[i] & {SAMPLE_BITS{hit[i]}});
        end
    end

    // shift-add smoother, weight three quarters on the median
    always_comb begin
        logic [SAMPLE_BITS+1:0] quarter_med;
        logic [SAMPLE_BITS+1:0] sum;
        quarter_med = (SAMPLE_BITS + 2)'(median >> 2);
        sum = (SAMPLE_BITS + 2)'(prev_reg[in_axis_reg] >> 2)
            + (quarter_med << 1) + quarter_med;
        if (in_req_reg == mte3_pkg::REQ_SEED) begin
            result_next = in_sample_reg;
        end else begin
            result_next = sum[SAMPLE_BITS-1:0];
        end
    end

    // handshake control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (out_ready) begin
                m_valid_reg <= in_valid_reg;
            end
            if (s_ready) begin
                // unused axis code is taken and dropped here
                in_valid_reg <= s_valid && (s_axis != mte3_pkg::AXIS_UNUSED);
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg    <= s_req_type;
            in_axis_reg   <= s_axis;
            in_sample_reg <= s_sample;
        end
        if (fire) begin
            m_axis_reg     <= in_axis_reg;
            m_filtered_reg <= result_next;
        end
    end

    // axis state, written in the same cycle the transaction is processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < AXES; a++) begin
                slot_reg[a] <= '0;
                prev_reg[a] <= '0;
                for (int k = 0; k < WINDOW_LEN; k++) begin
                    win_reg[a][k] <= '0;
                end
            end
        end else if (fire) begin
            slot_reg[in_axis_reg] <= slot_next;
            prev_reg[in_axis_reg] <= result_next;
            for (int k = 0; k < WINDOW_LEN; k++) begin
                win_reg[in_axis_reg][k] <= new_win[k];
            end
        end
    end

    // a valid result never carries the unused axis code
    `ASSERT_CLKD(a_no_unused_axis, aclk, aresetn,
        m_valid_reg |-> (m_axis_reg != mte3_pkg::AXIS_UNUSED),
        "result transaction carries unused axis code")

    // write slots stay inside the window
    `ASSERT_CLKD(a_slot_in_range, aclk, aresetn,
        (slot_reg[0] < slot_t'(WINDOW_LEN)) && (slot_reg[1] < slot_t'(WINDOW_LEN)) &&
        (slot_reg[2] < slot_t'(WINDOW_LEN)),
        "window write slot out of range")

    // a seed answers with its own sample
    `ASSERT_CLKD(a_seed_echo, aclk, aresetn,
        (fire && (in_req_reg == mte3_pkg::REQ_SEED)) |=>
            (m_valid_reg && (m_filtered_reg == $past(in_sample_reg))),
        "seed result differs from seed sample")

    // a taken transaction on a real axis always enters the input stage
    `ASSERT_CLKD(a_accept_loads, aclk, aresetn,
        (s_valid && s_ready && (s_axis != mte3_pkg::AXIS_UNUSED)) |=> in_valid_reg,
        "accepted transaction lost before processing")

endmodule
